### hw/rtl/isq_pkg.sv
// Shared constants and helpers for the integer square root pipeline.
// No dependencies; every other file in this block refers to it by scoped names.
`timescale 1ns / 1ps

package isq_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int MAX_WIDTH      = 64;
   localparam int POS_WIDTH      = 6;

   // Index of the highest set bit, found by halving the search range each step.
   // A zero operand returns zero; callers handle that case on their own.
   function automatic logic [POS_WIDTH-1:0] top_bit(input logic [MAX_WIDTH-1:0] v);
      logic [MAX_WIDTH-1:0] w;
      logic [POS_WIDTH-1:0] pos;
      w   = v;
      pos = '0;
      for (int s = POS_WIDTH - 1; s >= 0; s--) begin
         if ((w >> (1 << s)) != '0) begin
            w      = w >> (1 << s);
            pos[s] = 1'b1;
         end
      end
      return pos;
   endfunction

endpackage

### hw/rtl/isq_req_if.sv
// Operand channel of the integer square root block: valid/ready plus the operand word.
// Depends on isq_pkg for the default width.
`timescale 1ns / 1ps

interface isq_req_if #(
   parameter int DATA_WIDTH = isq_pkg::DATA_WIDTH_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

### hw/rtl/isq_rsp_if.sv
// Result channel of the integer square root block: valid/ready plus the root word.
// Depends on isq_pkg for the default width.
`timescale 1ns / 1ps

interface isq_rsp_if #(
   parameter int DATA_WIDTH = isq_pkg::DATA_WIDTH_DEF
) ();
   localparam int ROOT_WIDTH = (DATA_WIDTH + 1) / 2;

   logic                  valid;
   logic                  ready;
   logic [ROOT_WIDTH-1:0] root;

   modport source (output valid, output root, input ready);
   modport sink   (input valid, input root, output ready);
endinterface

### hw/rtl/integer_sqrt_clz_bsearch_top.sv
// Integer square root: top bit search followed by a pipelined binary search.
// Depends on isq_pkg, isq_req_if and isq_rsp_if.
//
// Usage:
//   req_ch carries one unsigned operand word (DATA_WIDTH bits) per handshake;
//   rsp_ch returns its floor square root ((DATA_WIDTH+1)/2 bits), one word
//   for every operand, in order.
//   Stage 0 finds the top set bit and seeds the bounds [2^(t/2), 2^(t/2+1)).
//   Each of the next (DATA_WIDTH+1)/2 - 1 stages does one square and compare
//   and halves the interval; the last stage is the output register.
// Path: an accepted operand is registered in stage 0 and then in each search
//   stage in order; rsp_ch.valid and rsp_ch.root come from the last stage's register.
// Throughput: one word per cycle while the receiver does not stall; each stage
//   holds its own square unit, so a new operand can enter on every clock that the pipeline is not held.
// Stall: while rsp_ch.valid is high and rsp_ch.ready is low, the whole
//   pipeline holds and req_ch.ready drops; nothing is lost or repeated.
// Reset: synchronous, active high; clears all stage valid bits, so the
//   pipeline comes up empty and ready on the next cycle. No other state.
`timescale 1ns / 1ps

module integer_sqrt_clz_bsearch_top #(
   parameter int DATA_WIDTH = isq_pkg::DATA_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   isq_req_if.sink     req_ch,
   isq_rsp_if.source   rsp_ch
);

   localparam int ROOT_WIDTH = (DATA_WIDTH + 1) / 2;
   localparam int SQ_WIDTH   = 2 * ROOT_WIDTH;
   localparam int STEPS      = ROOT_WIDTH - 1;
   localparam int PW         = isq_pkg::POS_WIDTH;
   localparam int MW         = isq_pkg::MAX_WIDTH;

   // per-stage pipeline registers, stage 0 is the seed, stage STEPS the output
   logic [STEPS:0]          vld_ff;
   logic [STEPS:0]          vld_in;
   logic [DATA_WIDTH-1:0]   value_ff [0:STEPS];
   logic [DATA_WIDTH-1:0]   value_in [0:STEPS];
   logic [ROOT_WIDTH-1:0]   lo_ff    [0:STEPS];
   logic [ROOT_WIDTH-1:0]   lo_in    [0:STEPS];
   logic [ROOT_WIDTH:0]     hi_ff    [0:STEPS];
   logic [ROOT_WIDTH:0]     hi_in    [0:STEPS];

   logic                    advance;
   logic [PW-1:0]           top_pos;
   logic [ROOT_WIDTH-1:0]   seed_lo;

   assign advance      = !vld_ff[STEPS] || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign rsp_ch.valid = vld_ff[STEPS];
   assign rsp_ch.root  = lo_ff[STEPS];

   assign top_pos = isq_pkg::top_bit(MW'(req_ch.value));
   assign seed_lo = ROOT_WIDTH'(1) << top_pos[PW-1:1];

   always_comb begin
      logic [ROOT_WIDTH:0]   sum;
      logic [ROOT_WIDTH-1:0] mid;
      logic [SQ_WIDTH-1:0]   sq;
      // seed stage: zero maps to [0, 1), which the search leaves at zero
      vld_in[0]   = req_ch.valid;
      value_in[0] = req_ch.value;
      if (req_ch.value == '0) begin
         lo_in[0] = '0;
         hi_in[0] = (ROOT_WIDTH + 1)'(1);
      end else begin
         lo_in[0] = seed_lo;
         hi_in[0] = (ROOT_WIDTH + 1)'(seed_lo) << 1;
      end
      // search stages; once hi = lo + 1 the midpoint is lo and the bounds stay put
      for (int i = 1; i <= STEPS; i++) begin
         sum         = (ROOT_WIDTH + 1)'(lo_ff[i-1]) + hi_ff[i-1];
         mid         = sum[ROOT_WIDTH:1];
         sq          = SQ_WIDTH'(mid) * SQ_WIDTH'(mid);
         vld_in[i]   = vld_ff[i-1];
         value_in[i] = value_ff[i-1];
         if (sq <= SQ_WIDTH'(value_ff[i-1])) begin
            lo_in[i] = mid;
            hi_in[i] = hi_ff[i-1];
         end else begin
            lo_in[i] = lo_ff[i-1];
            hi_in[i] = (ROOT_WIDTH + 1)'(mid);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i <= STEPS; i++) begin
            value_ff[i] <= value_in[i];
            lo_ff[i]    <= lo_in[i];
            hi_ff[i]    <= hi_in[i];
         end
      end
   end

`ifndef NO_ASSERTIONS
   // seed bounds always form a non-empty interval
   a_seed_order: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |-> ((ROOT_WIDTH + 1)'(lo_ff[0]) < hi_ff[0]))
      else $error("seed interval empty");

   // delivered root is the floor square root of its operand
   a_root_low: assert property (@(posedge clock) disable iff (reset)
      vld_ff[STEPS] |->
         ((2 * SQ_WIDTH)'(lo_ff[STEPS]) * (2 * SQ_WIDTH)'(lo_ff[STEPS])
            <= (2 * SQ_WIDTH)'(value_ff[STEPS])))
      else $error("root too large");

   a_root_high: assert property (@(posedge clock) disable iff (reset)
      vld_ff[STEPS] |->
         (((2 * SQ_WIDTH)'(lo_ff[STEPS]) + 1) * ((2 * SQ_WIDTH)'(lo_ff[STEPS]) + 1)
            > (2 * SQ_WIDTH)'(value_ff[STEPS])))
      else $error("root too small");

   // a held pipeline keeps every stage's occupancy
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff))
      else $error("stage valid changed during stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (vld_ff == '0))
      else $error("pipeline not empty after reset");
`endif

endmodule

### dv/isq_root_checker.sv
// Scoreboard for the integer square root block: watches both channels,
// computes the floor root of every accepted operand and compares it in order.
// Depends on isq_pkg, isq_req_if and isq_rsp_if.
`timescale 1ns / 1ps

module isq_root_checker (
   input  logic clock,
   input  logic reset,
   isq_req_if   req_ch,
   isq_rsp_if   rsp_ch,
   output int   mismatches,
   output int   outstanding
);

   localparam int OPND_W = isq_pkg::DATA_WIDTH_DEF;
   localparam int ROOT_W = (OPND_W + 1) / 2;

   typedef struct packed {
      logic [OPND_W-1:0] operand;
      logic [ROOT_W-1:0] root;
   } root_entry_type;

   root_entry_type pending_roots[$];
   int             fail_cnt = 0;
   int             open_cnt = 0;

   assign mismatches  = fail_cnt;
   assign outstanding = open_cnt;

   // Digit-by-digit root: set each root bit from the top down while the
   // trial square still fits under the operand.
   function automatic logic [ROOT_W-1:0] floor_sqrt(input logic [OPND_W-1:0] v);
      logic [ROOT_W-1:0]   r;
      logic [ROOT_W-1:0]   trial;
      logic [2*ROOT_W-1:0] sq;
      r = '0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
         trial = r | (ROOT_W'(1) << b);
         sq    = (2*ROOT_W)'(trial) * (2*ROOT_W)'(trial);
         if (sq <= (2*ROOT_W)'(v))
            r = trial;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      root_entry_type head;
      if (!reset) begin
         // pop before push: a word accepted this edge can't be answered this edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_roots.size() == 0) begin
               $display("%0t: unexpected root word: expected none, got %0d",
                        $time, rsp_ch.root);
               fail_cnt <= fail_cnt + 1;
            end else begin
               head = pending_roots.pop_front();
               if (rsp_ch.root !== head.root) begin
                  $display("%0t: root of %h: expected %0d, got %0d",
                           $time, head.operand, head.root, rsp_ch.root);
                  fail_cnt <= fail_cnt + 1;
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            pending_roots.push_back('{req_ch.value, floor_sqrt(req_ch.value)});
         open_cnt <= pending_roots.size();
      end
   end

endmodule

### dv/tb_top.sv
// Top of the integer square root testbench: clock, reset, operand stimulus
// with random idling on both channels, watchdog and verdict.
// Depends on isq_pkg, isq_req_if, isq_rsp_if, isq_root_checker and the block.
`timescale 1ns / 1ps

module tb_top;

   localparam int OPND_W      = isq_pkg::DATA_WIDTH_DEF;
   localparam int RAND_WORDS  = 1000;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 24;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   idle_on = 1'b1;
   int   quiet_cycles = 0;
   int   mismatches;
   int   outstanding;

   isq_req_if #(.DATA_WIDTH(OPND_W)) req_ch ();
   isq_rsp_if #(.DATA_WIDTH(OPND_W)) rsp_ch ();

   always #10 clock = ~clock;

   integer_sqrt_clz_bsearch_top #(.DATA_WIDTH(OPND_W)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   isq_root_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // Entered at a falling edge; returns at the falling edge after acceptance.
   task automatic send_operand(input logic [OPND_W-1:0] v);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.value <= v;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Random operand: mixes full-range words, short words of random width,
   // squares and their neighbors, and tiny values.
   function automatic logic [OPND_W-1:0] pick_operand();
      logic [OPND_W-1:0] v;
      logic [15:0]       r;
      int                w;
      case ($urandom_range(0, 3))
         0: v = $urandom();
         1: begin
            w = $urandom_range(1, OPND_W);
            v = $urandom() >> (OPND_W - w);
         end
         2: begin
            r = 16'($urandom());
            v = OPND_W'(r) * OPND_W'(r) + OPND_W'($urandom_range(0, 2)) - 1;
         end
         default: v = $urandom_range(0, 300);
      endcase
      return v;
   endfunction

   // Result side: ready drops in random bursts while idling is on.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 4) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog: cycles with no word moving on either channel.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      logic [OPND_W-1:0] edge_vals[$];
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero, tiny values, powers of two, all-ones, squares at the top end
      edge_vals = '{32'h0, 32'h1, 32'h2, 32'h3, 32'h4, 32'h8, 32'hF, 32'h10, 32'h11,
                    32'h1E, 32'h0000_FFFF, 32'h0001_0000, 32'h0100_0000, 32'h1000_0000,
                    32'h55AF * 32'h55AF, 32'h55AF * 32'h55AF - 1, 32'h5555_5555,
                    32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFE_0000,
                    32'hFFFE_0001, 32'hFFFE_0002, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
      foreach (edge_vals[i])
         send_operand(edge_vals[i]);

      // idling alternates in stretches of 100 words; the tail runs flat out
      for (int n = 0; n < RAND_WORDS; n++) begin
         idle_on = (n < RAND_WORDS - 200) && ((n / 100) % 2 == 0);
         send_operand(pick_operand());
      end
      req_ch.valid <= 1'b0;

      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
